[sv/assert_macros.svh]
// Assertion macros shared by the search block modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define GMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define GMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/gmdfs_pkg.sv]
// Package: constants, codes and types of the maze depth-first search block.
`timescale 1ns / 1ps
package gmdfs_pkg;

  localparam int COORD_W     = 4;
  localparam int GRID_DIM    = 1 << COORD_W;
  localparam int CELLS       = GRID_DIM * GRID_DIM;
  localparam int CELL_W      = 2 * COORD_W;
  localparam int STACK_DEPTH = 1024;
  localparam int STACK_AW    = $clog2(STACK_DEPTH);
  localparam int SP_W        = STACK_AW + 1;
  localparam int ENTRY_W     = 2 * CELL_W;
  localparam int CNT_W       = 9;
  localparam int SAT_MAX     = (1 << CNT_W) - 1;
  localparam int KIND_W      = 2;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;
  localparam int RIDX_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;

  // cell kinds
  localparam logic [KIND_W-1:0] KIND_OPEN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WALL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXIT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD  = 2'd3;

  // op codes
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ACK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ROUTE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BEYOND   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [KIND_W-1:0]  cell_kind;
    logic [RIDX_W-1:0]  route_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    route_length;
    logic [CNT_W-1:0]    dead_end_count;
    logic [COORD_W-1:0]  cell_row;
    logic [COORD_W-1:0]  cell_col;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic                capture;
    logic                init;
    logic                clr_wr;
    logic                par_start;
    logic                rd_here;
    logic                mark;
    logic                nb_rd;
    logic                nb_push;
    logic                nb_next;
    logic                dead_inc;
    logic                pop_rd;
    logic                pop_vis_rd;
    logic                pop_take;
    logic                rt_init;
    logic                rt_rd;
    logic                rt_step;
    logic                fill_init;
    logic                fill_wr;
    logic                fill_step;
    logic                found_set;
    logic                route_rd;
    logic                res_set;
    logic [STATUS_W-1:0] res_code;
    logic                res_cell;
    logic                out_load;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            start_ok;
    logic            clr_last;
    logic            here_exit;
    logic            nb_in_grid;
    logic            nb_ok;
    logic            nb_last;
    logic            sp_full;
    logic            sp_zero;
    logic            pushed;
    logic            pop_fresh;
    logic            rt_more;
    logic            fill_done;
    logic            ri_ok;
    logic            out_free;
  } sts_t;

endpackage

[sv/gmdfs_if.sv]
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps
interface gmdfs_in_if import gmdfs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [COORD_W-1:0]  row;
  logic [COORD_W-1:0]  col;
  logic [KIND_W-1:0]   cell_kind;
  logic [RIDX_W-1:0]   route_index;
  modport source (output valid, op, row, col, cell_kind, route_index, input ready);
  modport sink (input valid, op, row, col, cell_kind, route_index, output ready);
endinterface

interface gmdfs_out_if import gmdfs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    route_length;
  logic [CNT_W-1:0]    dead_end_count;
  logic [COORD_W-1:0]  cell_row;
  logic [COORD_W-1:0]  cell_col;
  modport source (output valid, status, route_length, dead_end_count, cell_row, cell_col,
                  input ready);
  modport sink (input valid, status, route_length, dead_end_count, cell_row, cell_col,
                output ready);
endinterface

interface gmdfs_cfg_if import gmdfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/gmdfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gmdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/gmdfs_dp.sv]
// Datapath: grid, visited, stack, parent and route memories plus search registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gmdfs_dp import gmdfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_item_t              in_item,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  // configuration and captured item
  logic [COORD_W-1:0] start_row_r, start_col_r;
  in_item_t           item_r;

  // search registers
  logic [CELL_W-1:0]  here_r, cur_r, clr_cnt_r;
  logic [SP_W-1:0]    sp_r;
  logic [1:0]         nb_r;
  logic               pushed_r;
  logic [CNT_W-1:0]   dead_r, found_r, n_r, steps_r;
  logic [STATUS_W-1:0] res_code_r;
  logic [COORD_W-1:0] res_row_r, res_col_r;
  out_item_t          out_r;
  logic               out_valid_r;

  // memory ports
  logic                grid_we, vis_we, stk_we, par_we, rt_we;
  logic [CELL_W-1:0]   grid_waddr, vis_waddr, par_waddr, rt_waddr;
  logic [CELL_W-1:0]   grid_raddr, vis_raddr, par_raddr, rt_raddr;
  logic [KIND_W-1:0]   grid_wdata, grid_q;
  logic [0:0]          vis_wdata, vis_q;
  logic [CELL_W-1:0]   par_wdata, par_q, rt_q;
  logic [ENTRY_W-1:0]  stk_wdata, stk_q;
  logic [STACK_AW-1:0] stk_raddr;
  logic [SP_W-1:0]     sp_m1;

  logic [CELL_W-1:0]   start_cell, nb_cell, pop_cell, pop_from;
  logic [COORD_W-1:0]  h_row, h_col, nb_row, nb_col;
  logic                nb_in_grid;

  assign start_cell = {start_row_r, start_col_r};
  assign h_row      = here_r[CELL_W-1:COORD_W];
  assign h_col      = here_r[COORD_W-1:0];
  assign pop_cell   = stk_q[ENTRY_W-1:CELL_W];
  assign pop_from   = stk_q[CELL_W-1:0];
  assign sp_m1      = sp_r - SP_W'(1);

  // neighbour in order up, down, left, right
  always_comb begin
    nb_row     = h_row;
    nb_col     = h_col;
    nb_in_grid = 1'b0;
    case (nb_r)
      2'd0: begin
        nb_row     = h_row - COORD_W'(1);
        nb_in_grid = (h_row != '0);
      end
      2'd1: begin
        nb_row     = h_row + COORD_W'(1);
        nb_in_grid = (h_row != COORD_W'(GRID_DIM - 1));
      end
      2'd2: begin
        nb_col     = h_col - COORD_W'(1);
        nb_in_grid = (h_col != '0);
      end
      default: begin
        nb_col     = h_col + COORD_W'(1);
        nb_in_grid = (h_col != COORD_W'(GRID_DIM - 1));
      end
    endcase
  end
  assign nb_cell = {nb_row, nb_col};

  // memory address and data selection
  always_comb begin
    grid_we    = cmd.capture && (in_item.op == OP_WRITE);
    grid_waddr = {in_item.row, in_item.col};
    grid_wdata = (in_item.cell_kind == KIND_BAD) ? KIND_WALL : in_item.cell_kind;
    grid_raddr = cmd.nb_rd ? nb_cell : here_r;

    vis_we    = cmd.clr_wr || cmd.mark;
    vis_waddr = cmd.clr_wr ? clr_cnt_r : here_r;
    vis_wdata = cmd.mark;
    vis_raddr = cmd.pop_vis_rd ? pop_cell : nb_cell;

    // popped entry is read at the pop and held at the new top afterward
    stk_we    = cmd.nb_push;
    stk_wdata = {nb_cell, here_r};
    stk_raddr = cmd.pop_rd ? sp_m1[STACK_AW-1:0] : sp_r[STACK_AW-1:0];

    par_we    = cmd.par_start || cmd.pop_take;
    par_waddr = cmd.pop_take ? pop_cell : here_r;
    par_wdata = cmd.pop_take ? pop_from : here_r;
    par_raddr = cur_r;

    rt_we    = cmd.fill_wr;
    rt_waddr = CELL_W'(steps_r - CNT_W'(1));
    rt_raddr = item_r.route_index;
  end

  gmdfs_ram #(.WIDTH(KIND_W), .DEPTH(CELLS)) u_grid (
    .clk, .we(grid_we), .waddr(grid_waddr), .wdata(grid_wdata),
    .raddr(grid_raddr), .rdata(grid_q));
  gmdfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
    .clk, .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_q));
  gmdfs_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(stk_we), .waddr(sp_r[STACK_AW-1:0]), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_q));
  gmdfs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_parent (
    .clk, .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_q));
  gmdfs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_route (
    .clk, .we(rt_we), .waddr(rt_waddr), .wdata(cur_r),
    .raddr(rt_raddr), .rdata(rt_q));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_row_r <= COORD_W'(1);
      start_col_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_START_ROW) begin
        start_row_r <= cfg_data;
      end
      if (cfg_index == REG_START_COL) begin
        start_col_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.init) begin
      here_r  <= start_cell;
      nb_r    <= '0;
      clr_cnt_r <= '0;
    end
    if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + CELL_W'(1);
    end
    if (cmd.mark) begin
      nb_r     <= '0;
      pushed_r <= 1'b0;
    end
    if (cmd.nb_next) begin
      nb_r <= nb_r + 2'd1;
    end
    if (cmd.nb_push) begin
      pushed_r <= 1'b1;
    end
    if (cmd.pop_take) begin
      here_r <= pop_cell;
    end
    if (cmd.rt_init) begin
      cur_r   <= here_r;
      n_r     <= CNT_W'(1);
      steps_r <= '0;
    end
    if (cmd.rt_step) begin
      cur_r   <= par_q;
      n_r     <= n_r + CNT_W'(1);
      steps_r <= steps_r + CNT_W'(1);
    end
    if (cmd.fill_init) begin
      cur_r   <= here_r;
      steps_r <= (n_r > CNT_W'(CELLS)) ? CNT_W'(CELLS) : n_r;
      n_r     <= (n_r > CNT_W'(CELLS)) ? CNT_W'(CELLS) : n_r;
    end
    if (cmd.fill_step) begin
      cur_r   <= par_q;
      steps_r <= steps_r - CNT_W'(1);
    end
    if (cmd.res_set) begin
      res_code_r <= cmd.res_code;
      res_row_r  <= cmd.res_cell ? rt_q[CELL_W-1:COORD_W] : '0;
      res_col_r  <= cmd.res_cell ? rt_q[COORD_W-1:0] : '0;
    end
    if (cmd.out_load) begin
      out_r <= '{status: res_code_r, route_length: found_r, dead_end_count: dead_r,
                 cell_row: res_row_r, cell_col: res_col_r};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      dead_r      <= '0;
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.init) begin
        sp_r    <= '0;
        dead_r  <= '0;
        found_r <= '0;
      end
      if (cmd.nb_push) begin
        sp_r <= sp_r + SP_W'(1);
      end
      if (cmd.pop_rd) begin
        sp_r <= sp_m1;
      end
      if (cmd.dead_inc && (dead_r != CNT_W'(SAT_MAX))) begin
        dead_r <= dead_r + CNT_W'(1);
      end
      if (cmd.found_set) begin
        found_r <= n_r;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // status back to the controller
  always_comb begin
    sts.op         = item_r.op;
    sts.start_ok   = ({1'b0, start_row_r} < (COORD_W + 1)'(GRID_DIM)) &&
                     ({1'b0, start_col_r} < (COORD_W + 1)'(GRID_DIM));
    sts.clr_last   = (clr_cnt_r == CELL_W'(CELLS - 1));
    sts.here_exit  = (grid_q == KIND_EXIT);
    sts.nb_in_grid = nb_in_grid;
    sts.nb_ok      = ((grid_q == KIND_OPEN) || (grid_q == KIND_EXIT)) && !vis_q[0];
    sts.nb_last    = (nb_r == 2'd3);
    sts.sp_full    = (sp_r == SP_W'(STACK_DEPTH));
    sts.sp_zero    = (sp_r == '0);
    sts.pushed     = pushed_r;
    sts.pop_fresh  = !vis_q[0];
    sts.rt_more    = (cur_r != start_cell) && (steps_r < CNT_W'(CELLS));
    sts.fill_done  = (steps_r == '0);
    sts.ri_ok      = ({1'b0, item_r.route_index} < found_r);
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `GMD_ASSERT_NOW(a_push_not_full, cmd.nb_push, sp_r != SP_W'(STACK_DEPTH), "push on full stack")
  `GMD_ASSERT_NOW(a_pop_not_empty, cmd.pop_rd, sp_r != '0, "pop on empty stack")
  `GMD_ASSERT_NEXT(a_sp_bound, cmd.nb_push || cmd.pop_rd, sp_r <= SP_W'(STACK_DEPTH),
                   "stack pointer beyond depth")

endmodule

[sv/gmdfs_ctrl.sv]
// Controller: sequences write, search, route rebuild and route read operations.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gmdfs_ctrl import gmdfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DEC  = 5'd1;
  localparam logic [4:0] S_CLR  = 5'd2;
  localparam logic [4:0] S_PAR  = 5'd3;
  localparam logic [4:0] S_RDH  = 5'd4;
  localparam logic [4:0] S_HERE = 5'd5;
  localparam logic [4:0] S_NBR  = 5'd6;
  localparam logic [4:0] S_NBC  = 5'd7;
  localparam logic [4:0] S_AFT  = 5'd8;
  localparam logic [4:0] S_POP  = 5'd9;
  localparam logic [4:0] S_POPW = 5'd10;
  localparam logic [4:0] S_POPC = 5'd11;
  localparam logic [4:0] S_RTC  = 5'd12;
  localparam logic [4:0] S_RTW  = 5'd13;
  localparam logic [4:0] S_FIL  = 5'd14;
  localparam logic [4:0] S_FLW  = 5'd15;
  localparam logic [4:0] S_RDW  = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.op)
          OP_SEARCH: begin
            cmd.init = 1'b1;
            if (sts.start_ok) begin
              state_nxt = S_CLR;
            end else begin
              cmd.res_set  = 1'b1;
              cmd.res_code = ST_NO_ROUTE;
              state_nxt    = S_DONE;
            end
          end
          OP_READ: begin
            if (sts.ri_ok) begin
              cmd.route_rd = 1'b1;
              state_nxt    = S_RDW;
            end else begin
              cmd.res_set  = 1'b1;
              cmd.res_code = ST_BEYOND;
              state_nxt    = S_DONE;
            end
          end
          default: begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_ACK;
            state_nxt    = S_DONE;
          end
        endcase
      end
      // sweep the visited marks clear
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_PAR;
        end
      end
      S_PAR: begin
        cmd.par_start = 1'b1;
        state_nxt     = S_RDH;
      end
      S_RDH: begin
        cmd.rd_here = 1'b1;
        state_nxt   = S_HERE;
      end
      S_HERE: begin
        if (sts.here_exit) begin
          cmd.rt_init = 1'b1;
          state_nxt   = S_RTC;
        end else begin
          cmd.mark  = 1'b1;
          state_nxt = S_NBR;
        end
      end
      // neighbour scan
      S_NBR: begin
        if (sts.nb_in_grid) begin
          cmd.nb_rd = 1'b1;
          state_nxt = S_NBC;
        end else if (sts.nb_last) begin
          state_nxt = S_AFT;
        end else begin
          cmd.nb_next = 1'b1;
        end
      end
      S_NBC: begin
        if (sts.nb_ok && sts.sp_full) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OVERFLOW;
          state_nxt    = S_DONE;
        end else begin
          cmd.nb_push = sts.nb_ok;
          if (sts.nb_last) begin
            state_nxt = S_AFT;
          end else begin
            cmd.nb_next = 1'b1;
            state_nxt   = S_NBR;
          end
        end
      end
      S_AFT: begin
        cmd.dead_inc = !sts.pushed;
        state_nxt    = S_POP;
      end
      // pop until an unvisited cell turns up
      S_POP: begin
        if (sts.sp_zero) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NO_ROUTE;
          state_nxt    = S_DONE;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = S_POPW;
        end
      end
      S_POPW: begin
        cmd.pop_vis_rd = 1'b1;
        state_nxt      = S_POPC;
      end
      S_POPC: begin
        if (sts.pop_fresh) begin
          cmd.pop_take = 1'b1;
          state_nxt    = S_RDH;
        end else begin
          state_nxt = S_POP;
        end
      end
      // count route cells back to the entry
      S_RTC: begin
        if (sts.rt_more) begin
          cmd.rt_rd = 1'b1;
          state_nxt = S_RTW;
        end else begin
          cmd.fill_init = 1'b1;
          state_nxt     = S_FIL;
        end
      end
      S_RTW: begin
        cmd.rt_step = 1'b1;
        state_nxt   = S_RTC;
      end
      // write the route store from the exit backward
      S_FIL: begin
        if (sts.fill_done) begin
          cmd.found_set = 1'b1;
          cmd.res_set   = 1'b1;
          cmd.res_code  = ST_FOUND;
          state_nxt     = S_DONE;
        end else begin
          cmd.fill_wr = 1'b1;
          cmd.rt_rd   = 1'b1;
          state_nxt   = S_FLW;
        end
      end
      S_FLW: begin
        cmd.fill_step = 1'b1;
        state_nxt     = S_FIL;
      end
      S_RDW: begin
        cmd.res_set  = 1'b1;
        cmd.res_code = ST_ACK;
        cmd.res_cell = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `GMD_ASSERT_NOW(a_load_free, cmd.out_load, sts.out_free, "result loaded over a waiting one")
  `GMD_ASSERT_NEXT(a_capture_dec, in_valid && in_ready, state_r == S_DEC,
                   "accepted transaction not decoded")

endmodule

[sv/grid_maze_depth_first_search.sv]
// Top level of the grid maze depth-first search block.
// A write op (op 0), an unused op or a route read (op 2) is decoded and its
// result loaded into the output register. A search (op 1) first sweeps the
// 256-entry visited memory clear, then for each expanded cell reads and marks
// it, scans its neighbours, reading and checking each one on the grid, and
// closes the step; it reads each popped stack entry and checks its visited
// mark, and rebuilds the route from the parent links, counting each route cell
// and then writing it to the route store. The controller sequences the reads
// of the single-port memories. One transaction is worked on at a time; a new
// one is taken while the previous result still sits in the output register.
`timescale 1ns / 1ps
module grid_maze_depth_first_search import gmdfs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  gmdfs_in_if.sink     in_item,
  gmdfs_out_if.source  out_item,
  gmdfs_cfg_if.sink    cfg_wr
);

  cmd_t      cmd;
  sts_t      sts;
  in_item_t  in_pl;
  out_item_t out_pl;

  assign in_pl = '{op: in_item.op, row: in_item.row, col: in_item.col,
                   cell_kind: in_item.cell_kind, route_index: in_item.route_index};

  assign cfg_wr.ready = 1'b1;

  gmdfs_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_item.valid),
    .in_ready(in_item.ready),
    .sts, .cmd
  );

  gmdfs_dp u_dp (
    .clk, .rst_n,
    .in_item(in_pl),
    .cfg_valid(cfg_wr.valid),
    .cfg_index(cfg_wr.index),
    .cfg_data(cfg_wr.data),
    .out_ready(out_item.ready),
    .out_valid(out_item.valid),
    .out_item(out_pl),
    .cmd, .sts
  );

  assign out_item.status         = out_pl.status;
  assign out_item.route_length   = out_pl.route_length;
  assign out_item.dead_end_count = out_pl.dead_end_count;
  assign out_item.cell_row       = out_pl.cell_row;
  assign out_item.cell_col       = out_pl.cell_col;

endmodule

[test/tb_grid_maze_depth_first_search.sv]
// Testbench for the grid maze depth-first search block: directed table, grid fill, random rounds.
`timescale 1ns / 1ps
module tb_grid_maze_depth_first_search;
  import gmdfs_pkg::*;

  // op code with no function
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  logic clk;
  logic rst_n;

  gmdfs_in_if  in_ch();
  gmdfs_out_if out_ch();
  gmdfs_cfg_if cfg_ch();

  grid_maze_depth_first_search i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_ch),
    .out_item(out_ch),
    .cfg_wr  (cfg_ch)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // maze state mirrored by the predictor
  logic [KIND_W-1:0]  maze_kind [CELLS];
  bit                 seen      [CELLS];
  logic [CELL_W-1:0]  push_cell [STACK_DEPTH];
  logic [CELL_W-1:0]  push_from [STACK_DEPTH];
  int                 depth;
  logic [CELL_W-1:0]  came_from [CELLS];
  logic [CELL_W-1:0]  route_cells [CELLS];
  int                 route_len;
  int                 dead_ends;
  logic [COORD_W-1:0] entry_row;
  logic [COORD_W-1:0] entry_col;

  out_item_t expected_results[$];
  int        mismatches;
  int        results_seen;
  bit        zero_gaps;

  // push one neighbour; 1 pushed, 0 rejected, -1 stack full
  function automatic int push_neighbor(int r, int c, logic [CELL_W-1:0] from);
    int idx;
    if (r < 0 || c < 0 || r >= GRID_DIM || c >= GRID_DIM) return 0;
    idx = r * GRID_DIM + c;
    if (maze_kind[idx] != KIND_OPEN && maze_kind[idx] != KIND_EXIT) return 0;
    if (seen[idx]) return 0;
    if (depth >= STACK_DEPTH) return -1;
    push_cell[depth] = CELL_W'(idx);
    push_from[depth] = from;
    depth++;
    return 1;
  endfunction

  function automatic logic [STATUS_W-1:0] search_maze();
    int entry, here, r, c, res, pushed, n, cur, steps;
    bit popped;
    foreach (seen[i]) seen[i] = 0;
    depth = 0;
    dead_ends = 0;
    route_len = 0;
    entry = entry_row * GRID_DIM + entry_col;
    here = entry;
    came_from[entry] = CELL_W'(entry);
    while (maze_kind[here] != KIND_EXIT) begin
      seen[here] = 1;
      r = here / GRID_DIM;
      c = here % GRID_DIM;
      pushed = 0;
      // up, down, left, right
      for (int k = 0; k < 4; k++) begin
        case (k)
          0: res = push_neighbor(r - 1, c, CELL_W'(here));
          1: res = push_neighbor(r + 1, c, CELL_W'(here));
          2: res = push_neighbor(r, c - 1, CELL_W'(here));
          default: res = push_neighbor(r, c + 1, CELL_W'(here));
        endcase
        if (res < 0) return ST_OVERFLOW;
        pushed += res;
      end
      if (pushed == 0 && dead_ends < SAT_MAX) dead_ends++;
      popped = 0;
      while (!popped) begin
        if (depth == 0) return ST_NO_ROUTE;
        depth--;
        if (!seen[push_cell[depth]]) begin
          here = push_cell[depth];
          came_from[here] = push_from[depth];
          popped = 1;
        end
      end
    end
    // rebuild route from the parent links
    n = 1;
    cur = here;
    for (steps = 0; cur != entry && steps < CELLS; steps++) begin
      cur = came_from[cur];
      n++;
    end
    if (n > CELLS) n = CELLS;
    cur = here;
    for (steps = n; steps > 0; steps--) begin
      route_cells[steps - 1] = CELL_W'(cur);
      cur = came_from[cur];
    end
    route_len = n;
    return ST_FOUND;
  endfunction

  // apply one transaction to the mirrored state and return its result
  function automatic out_item_t apply_item(in_item_t it);
    out_item_t o;
    o = '0;
    case (it.op)
      OP_WRITE:
        maze_kind[{it.row, it.col}] = (it.cell_kind == KIND_BAD) ? KIND_WALL : it.cell_kind;
      OP_SEARCH: o.status = search_maze();
      OP_READ: begin
        if (it.route_index < route_len) begin
          o.cell_row = route_cells[it.route_index][CELL_W-1:COORD_W];
          o.cell_col = route_cells[it.route_index][COORD_W-1:0];
        end else begin
          o.status = ST_BEYOND;
        end
      end
      default: ;
    endcase
    o.route_length   = CNT_W'(route_len);
    o.dead_end_count = CNT_W'(dead_ends);
    return o;
  endfunction

  function automatic int draw_gap();
    return zero_gaps ? 0 : $urandom_range(0, 11);
  endfunction

  // drive one transaction; typed_res overrides the predicted result
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    int gap;
    out_item_t o;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= it.op;
    in_ch.row         <= it.row;
    in_ch.col         <= it.col;
    in_ch.cell_kind   <= it.cell_kind;
    in_ch.route_index <= it.route_index;
    do @(posedge clk); while (!in_ch.ready);
    o = apply_item(it);
    expected_results.push_back(typed ? typed_res : o);
  endtask

  task automatic send(logic [OP_W-1:0] op, int r, int c, int kind, int idx);
    in_item_t it;
    it = '{op: op, row: COORD_W'(r), col: COORD_W'(c), cell_kind: KIND_W'(kind),
           route_index: RIDX_W'(idx)};
    send_item(it, 1'b0, '0);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // register write, only while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_START_ROW) entry_row = val;
    else entry_col = val;
  endtask

  task automatic set_entry(int r, int c);
    drain();
    write_reg(REG_START_ROW, CFG_DATA_W'(r));
    write_reg(REG_START_COL, CFG_DATA_W'(c));
  endtask

  function automatic int random_kind();
    int p;
    p = $urandom_range(0, 99);
    if (p < 66) return KIND_OPEN;
    if (p < 90) return KIND_WALL;
    if (p < 95) return KIND_BAD;
    return KIND_EXIT;
  endfunction

  // random edits, one search, then route reads (some sent as the spare op)
  task automatic search_round(int edits, int reads);
    int idx;
    for (int i = 0; i < edits; i++)
      send(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15), random_kind(),
           $urandom_range(0, 255));
    if ($urandom_range(0, 1))
      send(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15), KIND_EXIT, 0);
    send(OP_SEARCH, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 3),
         $urandom_range(0, 255));
    for (int i = 0; i < reads; i++) begin
      if (route_len > 0 && $urandom_range(0, 3) != 0) idx = $urandom_range(0, route_len - 1);
      else if ($urandom_range(0, 1)) idx = route_len;
      else idx = $urandom_range(0, 255);
      send($urandom_range(0, 7) == 0 ? OP_SPARE : OP_READ, $urandom_range(0, 15),
           $urandom_range(0, 15), $urandom_range(0, 3), idx);
    end
  endtask

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } row_t;

  localparam out_item_t ACK_RES    = '{default: '0};
  localparam out_item_t BEYOND_RES = '{status: ST_BEYOND, default: '0};

  // checks before any search: grid writes, unused op, reads of an empty route
  row_t early_rows[] = '{
    '{'{OP_READ,   4'd0,  4'd0,  2'd0, 8'd0},   1'b1, BEYOND_RES},
    '{'{OP_READ,   4'd15, 4'd15, KIND_BAD, 8'd255}, 1'b1, BEYOND_RES},
    '{'{OP_SPARE,  4'd15, 4'd15, KIND_BAD, 8'd255}, 1'b1, ACK_RES},
    '{'{OP_SPARE,  4'd0,  4'd0,  2'd0, 8'd0},   1'b1, ACK_RES},
    '{'{OP_WRITE,  4'd0,  4'd0,  KIND_OPEN, 8'd255}, 1'b1, ACK_RES},
    '{'{OP_WRITE,  4'd15, 4'd15, KIND_BAD,  8'd0},   1'b1, ACK_RES},
    '{'{OP_WRITE,  4'd0,  4'd15, KIND_EXIT, 8'd170}, 1'b1, ACK_RES},
    '{'{OP_WRITE,  4'd15, 4'd0,  KIND_WALL, 8'd85},  1'b1, ACK_RES},
    '{'{OP_WRITE,  4'd10, 4'd5,  KIND_OPEN, 8'd0},   1'b1, ACK_RES},
    '{'{OP_READ,   4'd5,  4'd10, 2'd1, 8'd1},   1'b1, BEYOND_RES},
    '{'{OP_READ,   4'd0,  4'd0,  2'd0, 8'd128}, 1'b0, ACK_RES}
  };

  // result checker
  always @(posedge clk) begin
    out_item_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.route_length, out_ch.dead_end_count,
              out_ch.cell_row, out_ch.cell_col};
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // result side: random stalls, one long hold-off once 30 results have been seen
  initial begin
    int gap;
    bit held;
    out_ch.ready = 1'b0;
    held = 0;
    @(posedge rst_n);
    forever begin
      if (!held && results_seen >= 30) begin
        gap = 300;
        held = 1;
      end else begin
        gap = draw_gap();
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // stimulus
  initial begin
    mismatches = 0;
    results_seen = 0;
    zero_gaps = 0;
    entry_row = 1;
    entry_col = 0;
    route_len = 0;
    dead_ends = 0;
    depth = 0;
    foreach (maze_kind[i]) maze_kind[i] = KIND_OPEN;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.cell_kind = '0;
    in_ch.route_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (early_rows[i]) send_item(early_rows[i].it, early_rows[i].typed, early_rows[i].res);

    // write every cell so no search reads an unwritten one
    for (int r = 0; r < GRID_DIM; r++) begin
      zero_gaps = (r % 4 == 1);
      for (int c = 0; c < GRID_DIM; c++)
        send(OP_WRITE, r, c, random_kind(), $urandom_range(0, 255));
    end
    zero_gaps = 0;

    // default entry, then entry as exit, then a walled-in entry
    search_round(0, 4);
    send(OP_WRITE, 1, 0, KIND_EXIT, 0);
    search_round(0, 2);
    send(OP_WRITE, 1, 0, KIND_OPEN, 0);
    send(OP_WRITE, 0, 0, KIND_WALL, 0);
    send(OP_WRITE, 2, 0, KIND_BAD, 0);
    send(OP_WRITE, 1, 1, KIND_WALL, 0);
    search_round(0, 2);

    // corner entries probe the grid border, then random entries
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_entry(0, 0);
        1: set_entry(15, 15);
        2: set_entry(0, 15);
        3: set_entry(15, 0);
        default: set_entry($urandom_range(0, 15), $urandom_range(0, 15));
      endcase
      zero_gaps = (ph % 3 == 2);
      search_round($urandom_range(0, 2), $urandom_range(1, 3));
    end

    drain();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
